// ===== rtl/hexd_pkg.sv =====
// Shared constants, types and hex digit helpers for the hex escape decoder.
package hexd_pkg;

   // Width of the per-string decoded byte counter (saturating)
   localparam int COUNT_WIDTH = 16;
   localparam int REPORT_WIDTH = 16;

   // Escape phase codes
   localparam logic [1:0] PH_IDLE = 2'd0;   // outside an escape
   localparam logic [1:0] PH_X    = 2'd1;   // expecting 'x'
   localparam logic [1:0] PH_HI   = 2'd2;   // expecting high digit
   localparam logic [1:0] PH_LO   = 2'd3;   // expecting low digit

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NON_ASCII = 2'd1;
   localparam logic [1:0] ST_BAD_ESC   = 2'd2;
   localparam logic [1:0] ST_UNTERM    = 2'd3;

   // Characters of interest
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_X_LOWER   = 8'h78;

   typedef struct packed {
      logic [1:0]             phase;
      logic                   bad;
      logic [3:0]             nibble;
      logic [COUNT_WIDTH-1:0] count;
      logic                   dropping;
   } dec_state_type;

   typedef struct packed {
      logic                    valid;
      logic [7:0]              out_byte;
      logic [1:0]              status;
      logic                    end_of_blob;
      logic [REPORT_WIDTH-1:0] decoded_count;
   } dec_rsp_type;

   // True for 0-9, A-F, a-f
   function automatic logic hex_ok(input logic [7:0] c);
      hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
   endfunction

   // Nibble value of a hex digit, zero otherwise
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end
      hex_val = v[3:0];
   endfunction

endpackage

// ===== rtl/hexd_decode.sv =====
// Escape phase state and per-character decode step.
module hexd_decode import hexd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,       // a character is processed this cycle
   input  logic [7:0]  in_char,
   input  logic        last_char,
   output dec_rsp_type rsp
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   dec_state_type state_ff;
   dec_state_type state_in;
   dec_state_type step;

   logic [COUNT_WIDTH-1:0]              count_new;
   logic [COUNT_WIDTH+REPORT_WIDTH-1:0] count_wide;
   logic                                emit;
   logic [1:0]                          status;
   logic [7:0]                          byte_val;

   // Saturating increment of the decoded byte count
   always_comb begin
      count_new = state_ff.count;
      if (state_ff.count != COUNT_MAX) begin
         count_new = state_ff.count + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      end
   end

   // One character of decode
   always_comb begin
      step     = state_ff;
      emit     = 1'b0;
      status   = ST_OK;
      byte_val = 8'd0;
      if (state_ff.dropping) begin
         if (last_char) begin
            step = '0;
         end
      end else begin
         case (state_ff.phase)
            PH_IDLE: begin
               if (in_char == CH_BACKSLASH) begin
                  if (last_char) begin
                     emit   = 1'b1;
                     status = ST_UNTERM;
                  end else begin
                     step.phase = PH_X;
                     step.bad   = 1'b0;
                  end
               end else if (in_char[7]) begin
                  emit   = 1'b1;
                  status = ST_NON_ASCII;
               end else begin
                  emit       = 1'b1;
                  step.count = count_new;
                  byte_val   = in_char;
               end
            end
            PH_X: begin
               if (last_char) begin
                  emit   = 1'b1;
                  status = ST_UNTERM;
               end else begin
                  step.bad   = state_ff.bad | (in_char != CH_X_LOWER);
                  step.phase = PH_HI;
               end
            end
            PH_HI: begin
               if (last_char) begin
                  emit   = 1'b1;
                  status = ST_UNTERM;
               end else begin
                  step.bad    = state_ff.bad | ~hex_ok(in_char);
                  step.nibble = hex_val(in_char);
                  step.phase  = PH_LO;
               end
            end
            default: begin
               emit       = 1'b1;
               step.phase = PH_IDLE;
               if (state_ff.bad || !hex_ok(in_char)) begin
                  status = ST_BAD_ESC;
               end else begin
                  step.count = count_new;
                  byte_val   = {state_ff.nibble, hex_val(in_char)};
               end
            end
         endcase
      end
   end

   // Result beat and the state left behind by it
   always_comb begin
      count_wide        = {{REPORT_WIDTH{1'b0}}, step.count};
      rsp.valid         = fire & emit;
      rsp.out_byte      = byte_val;
      rsp.status        = status;
      rsp.end_of_blob   = last_char;
      rsp.decoded_count = count_wide[REPORT_WIDTH-1:0];
      state_in          = step;
      if (emit) begin
         if (last_char) begin
            state_in = '0;
         end else if (status != ST_OK) begin
            state_in.phase    = PH_IDLE;
            state_in.bad      = 1'b0;
            state_in.nibble   = 4'd0;
            state_in.dropping = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // An error before the end of a string starts discarding
   a_err_drops: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.end_of_blob && rsp.status != ST_OK |=> state_ff.dropping)
      else $error("error without discard");

   // Discarding only ever happens outside an escape
   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.dropping |-> state_ff.phase == PH_IDLE)
      else $error("discarding inside escape");

   // Error results carry a zero byte
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_OK |-> rsp.out_byte == 8'd0)
      else $error("error result with data");

endmodule

// ===== rtl/hexd_rsp_reg.sv =====
// Result register facing the output stream.
module hexd_rsp_reg import hexd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,    // decode step taken this cycle
   input  dec_rsp_type rsp,
   input  logic        rsp_tready,
   output logic        can_load,
   output logic        rsp_tvalid,
   output dec_rsp_type rsp_data
);

   logic        valid_ff;
   logic        valid_in;
   dec_rsp_type data_ff;
   logic        load;

   assign can_load = ~valid_ff | rsp_tready;
   assign load     = advance & rsp.valid;

   // Hold until taken, reload when a new result arrives
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

// ===== rtl/hex_escape_blob_decoder.sv =====
// Top level of the backslash-x hex escape decoder.
// Decodes an escaped text string, one character per beat on req_, into blob
// bytes on rsp_. Plain ASCII passes through, "\xHH" gives one byte, and the
// first error of a string (non-ASCII, bad escape, string ending inside an
// escape) is reported once, after which the rest of that string is dropped.
// One character is accepted every cycle unless rsp_ back-pressure holds both
// registers full; a character that produces a result passes from the input
// register into the result register, which shows it on rsp_. The decode step
// sits between those two registers and is a single phase update plus a
// saturating 16-bit increment. req_tready follows rsp_tready combinationally
// when both the input register and the result register are full.
module hex_escape_blob_decoder import hexd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [23:8] decoded_count
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // end_of_blob
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  char_ff;
   logic        last_ff;
   logic        can_load;
   logic        advance;
   logic        req_beat;
   dec_rsp_type dec_rsp;
   dec_rsp_type out_rsp;

   assign advance    = in_valid_ff & can_load;
   assign req_tready = ~in_valid_ff | can_load;
   assign req_beat   = req_tvalid & req_tready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   hexd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .in_char   (char_ff),
      .last_char (last_ff),
      .rsp       (dec_rsp)
   );

   hexd_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .rsp        (dec_rsp),
      .rsp_tready (rsp_tready),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (out_rsp)
   );

   assign rsp_tdata = {out_rsp.decoded_count, out_rsp.out_byte};
   assign rsp_tuser = out_rsp.status;
   assign rsp_tlast = out_rsp.end_of_blob;

   // A decoded result always lands in the result register
   a_rsp_lands: assert property (@(posedge clock) disable iff (reset)
      advance && dec_rsp.valid |=> rsp_tvalid)
      else $error("result lost");

   // A held input character is never overwritten
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !can_load |-> !req_tready)
      else $error("input register overrun");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the backslash-x hex escape decoder.
`timescale 1ns / 100ps

module tb import hexd_pkg::*; ();

   localparam logic [7:0] ASCII_MAX = 8'd127;
   localparam int         RAND_CHARS = 1150;

   // One expected decoder result
   typedef struct {
      logic [7:0]  out_byte;
      logic [1:0]  status;
      logic        eob;
      logic [15:0] count;
   } blob_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_char
   logic        req_tlast;   // last_char
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [7:0] out_byte, [23:8] decoded_count
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        rsp_tlast;   // end_of_blob

   blob_result_type blob_results_q[$];
   int              errors;
   int              rx_wait;
   bit              quiet;      // no idling on either side while set

   // Predictor state, one string at a time
   logic [1:0]             esc_phase;
   bit                     esc_bad;
   logic [3:0]             hi_nib;
   logic [COUNT_WIDTH-1:0] str_count;
   bit                     dropping;

   hex_escape_blob_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int draw_wait();
      return quiet ? 0 : $urandom_range(0, 17);
   endfunction

   // Hex digit value, -1 when not a digit
   function automatic int hex_digit(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   // Digit character for a nibble, letters in random case
   function automatic logic [7:0] hex_char(input int v);
      if (v < 10) return 8'(8'h30 + v);
      if ($urandom_range(0, 1) == 1) return 8'(8'h41 + v - 10);
      return 8'(8'h61 + v - 10);
   endfunction

   function automatic logic [7:0] rand_plain();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 127)); while (c == CH_BACKSLASH);
      return c;
   endfunction

   function automatic void clear_string();
      esc_phase = PH_IDLE;
      esc_bad   = 1'b0;
      hi_nib    = 4'd0;
      str_count = '0;
      dropping  = 1'b0;
   endfunction

   function automatic void bump_count();
      if (str_count != '1) str_count = str_count + 1'b1;
   endfunction

   // Queue one result and apply its effect on the string state
   function automatic void emit_result(input logic [7:0] b, input logic [1:0] st,
                                       input bit eob);
      blob_result_type r;
      r.out_byte = b;
      r.status   = st;
      r.eob      = eob;
      r.count    = str_count[15:0];
      blob_results_q.push_back(r);
      if (eob) begin
         clear_string();
      end else if (st != ST_OK) begin
         esc_phase = PH_IDLE;
         esc_bad   = 1'b0;
         hi_nib    = 4'd0;
         dropping  = 1'b1;
      end
   endfunction

   // Decode one accepted character into zero or one expected result
   function automatic void decode_char(input logic [7:0] c, input bit last);
      int v;
      if (dropping) begin
         if (last) clear_string();
         return;
      end
      case (esc_phase)
         PH_IDLE: begin
            if (c == CH_BACKSLASH) begin
               if (last) emit_result(8'd0, ST_UNTERM, 1'b1);
               else begin
                  esc_phase = PH_X;
                  esc_bad   = 1'b0;
               end
            end else if (c > ASCII_MAX) begin
               emit_result(8'd0, ST_NON_ASCII, last);
            end else begin
               bump_count();
               emit_result(c, ST_OK, last);
            end
         end
         PH_X: begin
            if (last) emit_result(8'd0, ST_UNTERM, 1'b1);
            else begin
               if (c != CH_X_LOWER) esc_bad = 1'b1;
               esc_phase = PH_HI;
            end
         end
         PH_HI: begin
            if (last) emit_result(8'd0, ST_UNTERM, 1'b1);
            else begin
               v = hex_digit(c);
               if (v < 0) begin
                  esc_bad = 1'b1;
                  hi_nib  = 4'd0;
               end else begin
                  hi_nib = v[3:0];
               end
               esc_phase = PH_LO;
            end
         end
         default: begin
            v = hex_digit(c);
            esc_phase = PH_IDLE;
            if (esc_bad || v < 0) emit_result(8'd0, ST_BAD_ESC, last);
            else begin
               bump_count();
               emit_result({hi_nib, v[3:0]}, ST_OK, last);
            end
         end
      endcase
   endfunction

   // Send one character; valid stays high across back-to-back beats
   task automatic send_char(input logic [7:0] c, input bit last);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      decode_char(c, last);
   endtask

   // Result side: random back-pressure and field-by-field compare
   always @(posedge clock) begin
      blob_result_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (blob_results_q.size() == 0) begin
               $display("%0t: unexpected result byte=%02h status=%0d eob=%0b count=%0d",
                        $time, rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[23:8]);
               errors++;
            end else begin
               e = blob_results_q.pop_front();
               if (rsp_tdata[7:0] !== e.out_byte) begin
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, e.out_byte, rsp_tdata[7:0]);
                  errors++;
               end
               if (rsp_tuser !== e.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, e.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tlast !== e.eob) begin
                  $display("%0t: end_of_blob expected %0b actual %0b",
                           $time, e.eob, rsp_tlast);
                  errors++;
               end
               if (rsp_tdata[23:8] !== e.count) begin
                  $display("%0t: decoded_count expected %0d actual %0d",
                           $time, e.count, rsp_tdata[23:8]);
                  errors++;
               end
            end
            rx_wait = draw_wait();
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         rsp_tready <= (rx_wait == 0);
      end
   end

   // Lowest and highest plain ASCII pass straight through
   task automatic test_plain();
      send_char(8'h00, 1'b0);
      send_char(ASCII_MAX, 1'b1);
   endtask

   // Well-formed escape with mixed-case digits
   task automatic test_escape();
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CH_X_LOWER, 1'b0);
      send_char("a", 1'b0);
      send_char("F", 1'b1);
   endtask

   // Byte above 127 mid-string drops the rest; also on the final character
   task automatic test_non_ascii();
      send_char(8'h80, 1'b0);
      send_char("z", 1'b0);
      send_char("q", 1'b1);
      send_char(8'hFF, 1'b1);
   endtask

   // Wrong marker and wrong high digit, reported on the fourth character
   task automatic test_bad_escape();
      send_char(CH_BACKSLASH, 1'b0);
      send_char("y", 1'b0);
      send_char("g", 1'b0);
      send_char("1", 1'b0);
      send_char("Z", 1'b1);
   endtask

   // String ends inside an escape: on the marker, on the backslash and on the high digit
   task automatic test_unterminated();
      send_char(CH_BACKSLASH, 1'b0);
      send_char("q", 1'b1);
      send_char(CH_BACKSLASH, 1'b1);
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CH_X_LOWER, 1'b0);
      send_char("4", 1'b1);
   endtask

   // Random strings: mostly well-formed, some broken escapes, noise and cut-offs
   task automatic test_random();
      logic [7:0] str_q[$];
      logic [7:0] ch;
      int         sent;
      int         n;
      int         kind;
      bit         broken;
      sent = 0;
      while (sent < RAND_CHARS) begin
         str_q.delete();
         quiet = ($urandom_range(0, 5) == 0);
         n = $urandom_range(1, 10);
         repeat (n) begin
            kind = $urandom_range(0, 19);
            if (kind < 13) begin
               str_q.push_back(rand_plain());
            end else if (kind < 19) begin
               broken = (kind == 18);
               str_q.push_back(CH_BACKSLASH);
               for (int k = 0; k < 3; k++) begin
                  ch = (k == 0) ? CH_X_LOWER : hex_char($urandom_range(0, 15));
                  if (broken && $urandom_range(0, 1) == 1) ch = 8'($urandom());
                  str_q.push_back(ch);
               end
            end else begin
               str_q.push_back(8'($urandom_range(0, 255)));
            end
         end
         // occasionally cut the string off inside an escape
         if ($urandom_range(0, 9) == 0) begin
            str_q.push_back(CH_BACKSLASH);
            repeat ($urandom_range(0, 2)) str_q.push_back(8'($urandom()));
         end
         for (int i = 0; i < str_q.size(); i++)
            send_char(str_q[i], i == str_q.size() - 1);
         sent += str_q.size();
      end
      quiet = 1'b0;
   endtask

   initial begin
      errors     = 0;
      quiet      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      req_tlast  = 1'b0;
      clear_string();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_plain();
      test_escape();
      test_non_ascii();
      test_bad_escape();
      test_unterminated();
      test_random();

      req_tvalid <= 1'b0;
      while (blob_results_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
